### design/bch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bch_pkg;

  // column store size and lane geometry
  localparam int MAX_COLUMNS_DEF = 2048;
  localparam int LANES           = 8;
  localparam int LANE_AW         = 3;
  localparam int LANE_CW         = 4;
  localparam int HASH_W          = 32;
  localparam int WIDTH_W         = 12;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd2048;

  // rows of finished hashes that may wait for the output side
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [7:0] byte_index;
    logic       last_row;
  } pixel_item_t;

  typedef struct packed {
    logic [10:0] column_index;
    logic [31:0] column_hash;
    logic        last_column;
  } hash_item_t;

  typedef logic [LANES-1:0][HASH_W-1:0] row_t;

  // one row of hashes on its way to the output, with its lane count
  typedef struct packed {
    row_t               hash;
    logic [7:0]         base;
    logic [LANE_CW-1:0] count;
  } fin_row_t;

  // one pixel bit into a running hash
  function automatic logic [HASH_W-1:0] mix_bit(input logic [HASH_W-1:0] h, input logic b);
    logic [HASH_W-1:0] h1;
    logic [HASH_W-1:0] h2;
    h1 = h + HASH_W'(b);
    h2 = h1 + (h1 << 10);
    return h2 ^ (h2 >> 6);
  endfunction

  // first half of the finalization
  function automatic logic [HASH_W-1:0] fin_a(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] h1;
    h1 = h + (h << 3);
    return h1 ^ (h1 >> 11);
  endfunction

  // second half of the finalization
  function automatic logic [HASH_W-1:0] fin_b(input logic [HASH_W-1:0] h);
    return h + (h << 15);
  endfunction

endpackage
`default_nettype wire

### design/bch_store.sv
`timescale 1ns / 1ps
`default_nettype none
module bch_store #(
  parameter int ROWS   = 256,
  parameter int ROW_AW = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 rd_en,
  input  wire  [ROW_AW-1:0]   rd_addr,
  output bch_pkg::row_t       rd_row,
  input  wire                 wr_en,
  input  wire  [ROW_AW-1:0]   wr_addr,
  input  bch_pkg::row_t       wr_row
);

  bch_pkg::row_t mem [ROWS];
  logic [ROWS-1:0] row_valid;
  bch_pkg::row_t rd_data;
  logic rd_vld;

  // row store with a registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // per-row valid bits, a row never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_vld ? rd_data : '0;

endmodule
`default_nettype wire

### design/bch_final.sv
`timescale 1ns / 1ps
`default_nettype none
module bch_final (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  bch_pkg::fin_row_t  in_row,
  output logic               out_valid,
  output bch_pkg::fin_row_t  out_row
);

  logic a_valid;
  logic b_valid;
  bch_pkg::fin_row_t a_row;
  bch_pkg::fin_row_t b_row;

  // control of the two finalize stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  // stage a holds mixed hashes, stage b the first finalize step
  always_ff @(posedge clk) begin
    a_row <= in_row;
    b_row.base  <= a_row.base;
    b_row.count <= a_row.count;
    for (int k = 0; k < bch_pkg::LANES; k++) begin
      b_row.hash[k] <= bch_pkg::fin_a(a_row.hash[k]);
    end
  end

  // last finalize step on the way to the queue
  always_comb begin
    out_row.base  = b_row.base;
    out_row.count = b_row.count;
    for (int k = 0; k < bch_pkg::LANES; k++) begin
      out_row.hash[k] = bch_pkg::fin_b(b_row.hash[k]);
    end
  end

  assign out_valid = b_valid;

endmodule
`default_nettype wire

### design/bch_drain.sv
`timescale 1ns / 1ps
`default_nettype none
module bch_drain (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  bch_pkg::fin_row_t   push_row,
  output logic                pop,
  output logic                hash_valid,
  input  wire                 hash_stall,
  output bch_pkg::hash_item_t hash_item
);

  localparam int PTR_W  = $clog2(bch_pkg::QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(bch_pkg::QUEUE_DEPTH + 1);

  bch_pkg::fin_row_t q_row [bch_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [QCNT_W-1:0] q_count;
  logic [bch_pkg::LANE_AW-1:0] lane;
  bch_pkg::fin_row_t head_row;
  logic load;
  logic lane_last;

  assign head_row  = q_row[head];
  assign load      = (q_count != '0) && (!hash_valid || !hash_stall);
  assign lane_last = (bch_pkg::LANE_CW'(lane) + bch_pkg::LANE_CW'(1)) == head_row.count;
  assign pop       = load && lane_last;

  // row storage, written at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      q_row[tail] <= push_row;
    end
  end

  // queue pointers and the lane walk over the head row
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      q_count <= '0;
      lane    <= '0;
    end else begin
      if (push) begin
        tail <= tail + PTR_W'(1);
      end
      if (pop) begin
        head <= head + PTR_W'(1);
      end
      q_count <= q_count + QCNT_W'(push) - QCNT_W'(pop);
      if (load) begin
        lane <= lane_last ? '0 : lane + bch_pkg::LANE_AW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (load) begin
      hash_valid <= 1'b1;
    end else if (!hash_stall) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hash_item.column_index <= {head_row.base, lane};
      hash_item.column_hash  <= head_row.hash[lane];
      hash_item.last_column  <= lane_last;
    end
  end

endmodule
`default_nettype wire

### design/bitmap_column_hash_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Column hash of a 1-bit bitmap, one running hash per pixel column.
// Pixel channel: pixel_valid / pixel_stall with pixel_item (byte, byte index,
// last-row flag). An item is taken on each edge with valid high and stall low.
// Hash channel: hash_valid / hash_stall with hash_item, one finished column
// hash per item, in column order, last_column marking the last of a byte.
// Config: cfg_valid / cfg_ready / cfg_data writes image_width; ready is
// always high, write only while the block is idle.
// Throughput: one pixel byte per cycle while pixel_stall is low, set by the
// read-modify-write of one eight-column store row per cycle with forwarding
// of the last write. Bytes of the last row give up to eight items each, which
// leave at one per cycle while hash_stall is low; up to four such bytes are
// buffered, then pixel_stall rises.
// Reset: store rows are marked empty at once (valid bit per row), image_width
// returns to 2048, no pass over the memory is needed.
// A stalled hash item holds; finalizing continues into the row queue.
module bitmap_column_hash_core #(
  parameter int MAX_COLUMNS = bch_pkg::MAX_COLUMNS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          pixel_valid,
  output logic                         pixel_stall,
  input  bch_pkg::pixel_item_t         pixel_item,
  output logic                         hash_valid,
  input  wire                          hash_stall,
  output bch_pkg::hash_item_t          hash_item,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [bch_pkg::WIDTH_W-1:0]  cfg_data
);

  localparam int ROWS_FULL = (MAX_COLUMNS + bch_pkg::LANES - 1) / bch_pkg::LANES;
  localparam int ROWS      = (ROWS_FULL > 256) ? 256 : ROWS_FULL;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CMP_RAW   = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W     = (CMP_RAW > bch_pkg::WIDTH_W) ? CMP_RAW : bch_pkg::WIDTH_W;
  localparam int CRED_W    = $clog2(bch_pkg::QUEUE_DEPTH + 1);

  logic [bch_pkg::WIDTH_W-1:0] image_width;
  logic accept;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] col0;
  logic [CMP_W-1:0] room;
  logic [bch_pkg::LANE_CW-1:0] in_n;
  logic [CRED_W-1:0] credits;
  logic pop;

  logic s1_valid;
  logic [7:0] s1_byte;
  logic [7:0] s1_index;
  logic s1_last;
  logic [bch_pkg::LANE_CW-1:0] s1_n;

  bch_pkg::row_t rd_row;
  bch_pkg::row_t cur_row;
  bch_pkg::row_t mixed;
  bch_pkg::row_t new_row;
  logic wr_en;
  logic fw_valid;
  logic [ROW_AW-1:0] fw_addr;
  bch_pkg::row_t fw_row;

  bch_pkg::fin_row_t fin_in;
  logic fin_valid;
  bch_pkg::fin_row_t fin_row;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = (credits == CRED_W'(bch_pkg::QUEUE_DEPTH));
  assign accept      = pixel_valid && !pixel_stall;

  // width register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= bch_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      image_width <= cfg_data;
    end
  end

  // number of columns of this byte below the effective width
  always_comb begin
    limit = (CMP_W'(image_width) < CMP_W'(MAX_COLUMNS)) ? CMP_W'(image_width)
                                                         : CMP_W'(MAX_COLUMNS);
    col0  = CMP_W'({pixel_item.byte_index, 3'b000});
    room  = limit - col0;
    if (limit <= col0) begin
      in_n = '0;
    end else if (room >= CMP_W'(bch_pkg::LANES)) begin
      in_n = bch_pkg::LANE_CW'(bch_pkg::LANES);
    end else begin
      in_n = room[bch_pkg::LANE_CW-1:0];
    end
  end

  // queue slots promised to last-row bytes with results
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CRED_W'(accept && pixel_item.last_row && (in_n != '0))
                         - CRED_W'(pop);
    end
  end

  // read stage item register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte  <= pixel_item.pixel_byte;
      s1_index <= pixel_item.byte_index;
      s1_last  <= pixel_item.last_row;
      s1_n     <= in_n;
    end
  end

  bch_store #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (pixel_item.byte_index[ROW_AW-1:0]),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (s1_index[ROW_AW-1:0]),
    .wr_row  (new_row)
  );

  // row as of the previous write, then the mix of each column in use
  always_comb begin
    cur_row = (fw_valid && (fw_addr == s1_index[ROW_AW-1:0])) ? fw_row : rd_row;
    for (int k = 0; k < bch_pkg::LANES; k++) begin
      mixed[k] = bch_pkg::mix_bit(cur_row[k], s1_byte[k]);
      if (bch_pkg::LANE_CW'(k) < s1_n) begin
        new_row[k] = s1_last ? '0 : mixed[k];
      end else begin
        new_row[k] = cur_row[k];
      end
    end
  end

  assign wr_en = s1_valid && (s1_n != '0);

  // last write, forwarded to the next read of the same row
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fw_addr <= s1_index[ROW_AW-1:0];
      fw_row  <= new_row;
    end
  end

  assign fin_in.hash  = mixed;
  assign fin_in.base  = s1_index;
  assign fin_in.count = s1_n;

  bch_final u_final (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wr_en && s1_last),
    .in_row    (fin_in),
    .out_valid (fin_valid),
    .out_row   (fin_row)
  );

  bch_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .push       (fin_valid),
    .push_row   (fin_row),
    .pop        (pop),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash_item  (hash_item)
  );

endmodule
`default_nettype wire

### design/bch_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bch_port_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  pixel_stall,
  input wire                  hash_valid,
  input wire                  hash_stall,
  input bch_pkg::hash_item_t  hash_item
);

  // a stalled hash item stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    hash_valid && hash_stall |=> hash_valid)
    else $error("hash item dropped while stalled");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    hash_valid && hash_stall |=> $stable(hash_item))
    else $error("hash item changed while stalled");

  // the eighth column of a byte always closes its run
  a_lane_last: assert property (@(posedge clk) disable iff (rst)
    hash_valid && (hash_item.column_index[2:0] == 3'd7) |-> hash_item.last_column)
    else $error("column 7 of a byte not marked last");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !hash_valid)
    else $error("hash item valid after reset");

  // input side open right after reset
  a_reset_open: assert property (@(posedge clk)
    rst |=> !pixel_stall)
    else $error("pixel input stalled after reset");

endmodule

bind bitmap_column_hash_core bch_port_checker u_bch_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_stall (pixel_stall),
  .hash_valid  (hash_valid),
  .hash_stall  (hash_stall),
  .hash_item   (hash_item)
);
`default_nettype wire

### tb/bch_checker.sv
`timescale 1ns / 1ps
module bch_checker #(
  parameter int MAX_COLUMNS = bch_pkg::MAX_COLUMNS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          pixel_valid,
  input  wire                          pixel_stall,
  input  bch_pkg::pixel_item_t         pixel_item,
  input  wire                          hash_valid,
  input  wire                          hash_stall,
  input  bch_pkg::hash_item_t          hash_item,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire  [bch_pkg::WIDTH_W-1:0]  cfg_data,
  output int                           errors,
  output int                           outstanding,
  output int                           hashes_seen
);

  // shadow copy of the column store and the width register
  logic [31:0]                 column_state [MAX_COLUMNS];
  logic [bch_pkg::WIDTH_W-1:0] width_reg;
  bch_pkg::hash_item_t         hash_expect_q [$];
  int                          err_cnt;
  int                          seen_cnt;

  // one pixel bit into a running one-at-a-time hash
  function automatic logic [31:0] oaat_mix(input logic [31:0] h, input logic b);
    logic [31:0] acc;
    acc = h + {31'd0, b};
    acc = acc + (acc << 10);
    acc = acc ^ (acc >> 6);
    return acc;
  endfunction

  // closing avalanche of the hash
  function automatic logic [31:0] oaat_finish(input logic [31:0] h);
    logic [31:0] acc;
    acc = h + (h << 3);
    acc = acc ^ (acc >> 11);
    acc = acc + (acc << 15);
    return acc;
  endfunction

  // mix one byte into its eight columns, queue finished hashes on the last row
  task automatic predict_byte(input bch_pkg::pixel_item_t it);
    bch_pkg::hash_item_t row_res [8];
    int                  n;
    int                  limit;
    int                  col;
    logic [31:0]         h;
    n = 0;
    limit = (int'(width_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(width_reg);
    for (int k = 0; k < 8; k++) begin
      col = int'(it.byte_index) * 8 + k;
      if (col < limit && col < MAX_COLUMNS) begin
        h = oaat_mix(column_state[col], it.pixel_byte[k]);
        if (it.last_row) begin
          row_res[n].column_index = col[10:0];
          row_res[n].column_hash  = oaat_finish(h);
          row_res[n].last_column  = 1'b0;
          column_state[col] = '0;
          n++;
        end else begin
          column_state[col] = h;
        end
      end
    end
    if (n > 0) row_res[n-1].last_column = 1'b1;
    for (int j = 0; j < n; j++) hash_expect_q.insert(hash_expect_q.size(), row_res[j]);
  endtask

  // compare one accepted hash item with the oldest expectation
  task automatic check_hash(input bch_pkg::hash_item_t got);
    bch_pkg::hash_item_t want;
    seen_cnt++;
    if (hash_expect_q.size() == 0) begin
      $error("hash item for column %0d with nothing expected", got.column_index);
      err_cnt++;
    end else begin
      want = hash_expect_q.pop_front();
      if (got.column_index !== want.column_index) begin
        $error("column_index: expected %0d, got %0d", want.column_index, got.column_index);
        err_cnt++;
      end
      if (got.column_hash !== want.column_hash) begin
        $error("column_hash: expected %08h, got %08h", want.column_hash, got.column_hash);
        err_cnt++;
      end
      if (got.last_column !== want.last_column) begin
        $error("last_column: expected %0b, got %0b", want.last_column, got.last_column);
        err_cnt++;
      end
    end
  endtask

  // watch all three channels
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COLUMNS; i++) column_state[i] = '0;
      width_reg = bch_pkg::WIDTH_RESET;
      hash_expect_q.delete();
      err_cnt = 0;
      seen_cnt = 0;
    end else begin
      if (hash_valid && !hash_stall) check_hash(hash_item);
      if (pixel_valid && !pixel_stall) predict_byte(pixel_item);
      if (cfg_valid && cfg_ready) width_reg = cfg_data;
    end
    errors      <= err_cnt;
    outstanding <= hash_expect_q.size();
    hashes_seen <= seen_cnt;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int RANDOM_ITEMS = 200;
  localparam int QUIET_ITEMS  = 40;
  localparam int IDLE_PAUSE   = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        pixel_valid;
  logic                        pixel_stall;
  bch_pkg::pixel_item_t        pixel_item;
  logic                        hash_valid;
  logic                        hash_stall;
  bch_pkg::hash_item_t         hash_item;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [bch_pkg::WIDTH_W-1:0] cfg_data;

  int                          errors;
  int                          outstanding;
  int                          hashes_seen;

  int                          items_sent;
  int                          widths_written;
  bit                          hold_req;
  bit                          quiet;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bitmap_column_hash_core dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_item  (pixel_item),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .hash_item   (hash_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  bch_checker chk (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_item  (pixel_item),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .hash_item   (hash_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .hashes_seen (hashes_seen)
  );

  // offer one pixel item and hold it until taken, then maybe idle a while
  task automatic send_pixel(input logic [7:0] bits, input logic [7:0] idx, input logic last);
    bch_pkg::pixel_item_t it;
    it.pixel_byte = bits;
    it.byte_index = idx;
    it.last_row   = last;
    pixel_item  <= it;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // write image_width once the block has drained
  task automatic write_width(input logic [bch_pkg::WIDTH_W-1:0] w);
    pixel_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (IDLE_PAUSE) @(posedge clk);
    cfg_data  <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    widths_written++;
  endtask

  // raster image of a given width, with the odd dropped, repeated or stray byte
  task automatic send_image(input int w, input int rows);
    int nbytes;
    nbytes = (w + 7) / 8;
    for (int r = 0; r < rows; r++) begin
      for (int b = 0; b < nbytes; b++) begin
        case ($urandom_range(0, 11))
          0: ;
          1: begin
            send_pixel(8'($urandom), 8'(b), r == rows - 1);
            send_pixel(8'($urandom), 8'(b), r == rows - 1);
          end
          default: send_pixel(8'($urandom), 8'(b), r == rows - 1);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        send_pixel(8'($urandom), 8'($urandom_range(nbytes, 255)), r == rows - 1);
      end
    end
  endtask

  // bytes with every field random
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    hash_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hash_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        hash_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        hash_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        hash_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // overall time limit
  initial begin
    #2000000;
    $display("bitmap_column_hash_core test failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int w;
    int drain;
    rst         <= 1'b1;
    pixel_valid <= 1'b0;
    pixel_item  <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    items_sent     = 0;
    widths_written = 0;
    hold_req       = 1'b0;
    quiet          = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset width: first and last groups, all-ones and all-zero bytes
    send_pixel(8'hFF, 8'd0, 1'b0);
    send_pixel(8'h00, 8'd255, 1'b1);
    send_pixel(8'hFF, 8'd0, 1'b1);
    send_pixel(8'hAA, 8'd1, 1'b0);
    send_pixel(8'h55, 8'd1, 1'b1);
    send_pixel(8'hFF, 8'd255, 1'b0);
    send_pixel(8'hFF, 8'd255, 1'b1);

    // zero width ignores everything
    write_width('0);
    send_pixel(8'hFF, 8'd0, 1'b1);
    send_pixel(8'hFF, 8'd200, 1'b0);

    // width above the store saturates
    write_width(12'd4095);
    send_pixel(8'h81, 8'd255, 1'b1);
    send_pixel(8'h7E, 8'd128, 1'b1);

    // single column
    write_width(12'd1);
    send_pixel(8'hFF, 8'd0, 1'b0);
    send_pixel(8'hFE, 8'd0, 1'b1);
    send_pixel(8'hFF, 8'd1, 1'b1);

    // partial last group, byte beyond the width
    write_width(12'd13);
    send_pixel(8'h5A, 8'd1, 1'b0);
    send_pixel(8'hFF, 8'd1, 1'b1);
    send_pixel(8'hFF, 8'd2, 1'b1);
    send_pixel(8'hC3, 8'd0, 1'b1);

    write_width(12'd2048);
    send_pixel(8'hFF, 8'd255, 1'b1);

    // fill the row queue while the result side holds off
    write_width(12'd64);
    hold_req = 1'b1;
    send_image(64, 2);

    // random images and noise under changing widths
    while (items_sent < RANDOM_ITEMS) begin
      quiet = (items_sent >= RANDOM_ITEMS - QUIET_ITEMS);
      if ($urandom_range(0, 3) != 0) begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 64);
        write_width(bch_pkg::WIDTH_W'(w));
        send_image(w, $urandom_range(1, 3));
      end else begin
        case ($urandom_range(0, 4))
          0: w = 0;
          1: w = 2048;
          2: w = 4095;
          3: w = $urandom_range(2049, 4095);
          default: w = $urandom_range(1, 4095);
        endcase
        write_width(bch_pkg::WIDTH_W'(w));
        send_noise($urandom_range(4, 10));
      end
    end
    pixel_valid <= 1'b0;

    // drain
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (outstanding != 0 && drain < DRAIN_LIMIT);
    if (outstanding != 0) begin
      $error("%0d expected hash items never arrived", outstanding);
      $display("bitmap_column_hash_core test failed");
      $finish;
    end else begin
      repeat (IDLE_PAUSE) @(posedge clk);
      $display("covered %0d pixel items and %0d hash items over %0d width writes",
               items_sent, hashes_seen, widths_written);
      $display("widths included zero, one, 2048 and 4095, plus a long result-side hold-off");
      if (errors == 0) begin
        $display("bitmap_column_hash_core test passed");
      end else begin
        $display("bitmap_column_hash_core test failed");
      end
      $finish;
    end
  end

endmodule

### bitmap_column_hash_core.f
design/bch_pkg.sv
design/bch_store.sv
design/bch_final.sv
design/bch_drain.sv
design/bitmap_column_hash_core.sv
design/bch_checker.sv
tb/bch_checker.sv
tb/tb.sv
